// ----- src/dle_stuffed_frame_receiver_assert.svh -----
// Assertion macros shared by the frame receiver modules.
`ifndef DLE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define DLE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define DLE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DLE_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define DLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/dle_rx_pkg.sv -----
// Types and constants shared by the frame receiver modules.
package dle_rx_pkg;

   localparam int DATA_BUFFER_SIZE_DEFAULT = 64;
   localparam int HEADER_BYTES             = 3;
   localparam int CHECKSUM_BYTES           = 1;
   localparam int QUEUE_DEPTH              = 2;
   localparam int CSR_IDX_W                = 1;

   localparam logic [7:0] FLAG_BYTE_RESET   = 8'd126;
   localparam logic [7:0] ESCAPE_BYTE_RESET = 8'd125;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLAG   = 1'b0,
      CSR_ESCAPE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BYTE_PLAIN  = 2'd0,
      BYTE_FLAG   = 2'd1,
      BYTE_ESCAPE = 2'd2
   } byte_class_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     value;
   } rx_item_type;

endpackage

// ----- src/dle_stuffed_frame_receiver.sv -----
// Top level of the byte-stuffed frame receiver.
// The request channel (req_) takes one raw line byte per request in req_tdata.
// The response channel (rsp_) gives at most one result per byte: rsp_tuser is
// the result kind, zero for a data byte with its buffer index and one for a
// completed frame with its control word, packet code and data length.
// The csr_ channel writes the flag byte (index 0) and the escape byte (index
// 1); it is always ready. The user must write it only while the receiver is
// idle; the block itself does not enforce this. An accepted byte passes the
// queue and the back end, and its result is registered before it shows on
// rsp_tvalid. One byte is taken every cycle while the consumer does not stall;
// the back end sets that rate, deciding each byte from its frame state bits.
// A two-entry queue of classified bytes and a registered result stage sit
// between the channels: when the consumer stalls the queue fills and req_tready
// falls, and no byte or result is lost.
// Reset restores the flag byte 0x7E and escape byte 0x7D and leaves the
// receiver outside a frame; no clearing pass is needed.
module dle_stuffed_frame_receiver #(
   parameter int DATA_BUFFER_SIZE = dle_rx_pkg::DATA_BUFFER_SIZE_DEFAULT,
   localparam int IDX_W = $clog2(DATA_BUFFER_SIZE - 2),
   localparam int RSP_W = 8 * ((2 * IDX_W + 32 + 7) / 8)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // rx_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_tuser,   // result_kind
   // data_index, data_value, control_word, packet_code, data_length, zero fill
   output logic [RSP_W-1:0]                 rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dle_rx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                       csr_data
);
   import dle_rx_pkg::*;

   logic        push_valid;
   logic        push_ready;
   rx_item_type push_item;
   logic        pop_valid;
   logic        pop_ready;
   rx_item_type pop_item;

   dle_rx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   dle_rx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   dle_rx_back #(
      .DATA_BUFFER_SIZE (DATA_BUFFER_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- src/dle_rx_front.sv -----
// Front end: holds the framing bytes and classifies each received byte.
module dle_rx_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dle_rx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [7:0]                            csr_data,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output dle_rx_pkg::rx_item_type               push_item
);
   import dle_rx_pkg::*;

   logic [7:0] flag_ff;
   logic [7:0] flag_in;
   logic [7:0] escape_ff;
   logic [7:0] escape_in;

   assign csr_ready = 1'b1;

   always_comb begin
      flag_in   = flag_ff;
      escape_in = escape_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FLAG:   flag_in   = csr_data;
            CSR_ESCAPE: escape_in = csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= FLAG_BYTE_RESET;
         escape_ff <= ESCAPE_BYTE_RESET;
      end else begin
         flag_ff   <= flag_in;
         escape_ff <= escape_in;
      end
   end

   // A byte that matches both framing values acts as a flag.
   always_comb begin
      push_item.value = req_tdata;
      if (req_tdata == flag_ff) begin
         push_item.cls = BYTE_FLAG;
      end else if (req_tdata == escape_ff) begin
         push_item.cls = BYTE_ESCAPE;
      end else begin
         push_item.cls = BYTE_PLAIN;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ----- src/dle_rx_queue.sv -----
// Short queue of classified bytes between the front and back ends.
module dle_rx_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  dle_rx_pkg::rx_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output dle_rx_pkg::rx_item_type pop_item
);
   import dle_rx_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rx_item_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `include "dle_stuffed_frame_receiver_assert.svh"

   `DLE_ASSERT_NEXT(a_pop_drains, clock, reset, pop_fire && !push_fire, count_ff == CNT_W'($past(count_ff) - 1'b1), "queue count did not fall after a pop")

endmodule

// ----- src/dle_rx_back.sv -----
// Back end: frame state, header capture and the registered result stage.
module dle_rx_back #(
   parameter int DATA_BUFFER_SIZE = dle_rx_pkg::DATA_BUFFER_SIZE_DEFAULT,
   localparam int IDX_W = $clog2(DATA_BUFFER_SIZE - 2),
   localparam int RSP_W = 8 * ((2 * IDX_W + 32 + 7) / 8)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  dle_rx_pkg::rx_item_type pop_item,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic                    rsp_tuser,
   output logic [RSP_W-1:0]        rsp_tdata
);
   import dle_rx_pkg::*;

   localparam int CNT_W = $clog2(DATA_BUFFER_SIZE + 3);

   logic             open_ff;
   logic             open_in;
   logic             good_ff;
   logic             good_in;
   logic             esc_ff;
   logic             esc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [15:0]      ctrl_ff;
   logic [15:0]      ctrl_in;
   logic [7:0]       code_ff;
   logic [7:0]       code_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_kind_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [7:0]       rsp_val_ff;
   logic [15:0]      rsp_ctrl_ff;
   logic [7:0]       rsp_code_ff;
   logic [IDX_W-1:0] rsp_len_ff;

   logic             advance;
   logic             item_fire;
   logic             emit;
   logic             emit_kind;
   logic [IDX_W-1:0] emit_idx;
   logic [7:0]       emit_val;
   logic [15:0]      emit_ctrl;
   logic [7:0]       emit_code;
   logic [IDX_W-1:0] emit_len;
   logic             is_flag;
   logic             is_escape;

   assign advance   = !rsp_valid_ff || rsp_tready;
   assign pop_ready = advance;
   assign item_fire = pop_valid && advance;

   assign is_flag   = (pop_item.cls == BYTE_FLAG) && !esc_ff;
   assign is_escape = (pop_item.cls == BYTE_ESCAPE) && good_ff && !esc_ff;

   always_comb begin
      open_in   = open_ff;
      good_in   = good_ff;
      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      ctrl_in   = ctrl_ff;
      code_in   = code_ff;
      emit      = 1'b0;
      emit_kind = KIND_DATA;
      emit_idx  = '0;
      emit_val  = '0;
      emit_ctrl = '0;
      emit_code = '0;
      emit_len  = '0;
      if (item_fire) begin
         if (is_flag) begin
            if (!open_ff) begin
               open_in = 1'b1;
               good_in = 1'b1;
               cnt_in  = '0;
               ctrl_in = '0;
               code_in = '0;
            end else if (!good_ff) begin
               open_in = 1'b0;
            end else if (cnt_ff != '0) begin
               emit      = 1'b1;
               emit_kind = KIND_FRAME;
               emit_ctrl = ctrl_ff;
               emit_code = code_ff;
               if (cnt_ff >= CNT_W'(HEADER_BYTES + CHECKSUM_BYTES)) begin
                  emit_len = IDX_W'(cnt_ff - CNT_W'(HEADER_BYTES + CHECKSUM_BYTES));
               end
               open_in = 1'b0;
               good_in = 1'b0;
            end
         end else if (is_escape) begin
            esc_in = 1'b1;
         end else begin
            if (good_ff) begin
               if (cnt_ff == CNT_W'(0)) begin
                  ctrl_in = {8'h00, pop_item.value};
               end else if (cnt_ff == CNT_W'(1)) begin
                  ctrl_in = {pop_item.value, ctrl_ff[7:0]};
               end else if (cnt_ff == CNT_W'(HEADER_BYTES - 1)) begin
                  code_in = pop_item.value;
               end else if (cnt_ff <= CNT_W'(DATA_BUFFER_SIZE)) begin
                  emit      = 1'b1;
                  emit_kind = KIND_DATA;
                  emit_idx  = IDX_W'(cnt_ff - CNT_W'(HEADER_BYTES));
                  emit_val  = pop_item.value;
               end else begin
                  good_in = 1'b0;
               end
               cnt_in = cnt_ff + 1'b1;
            end
            esc_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = item_fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         good_ff      <= 1'b0;
         esc_ff       <= 1'b0;
         cnt_ff       <= '0;
         ctrl_ff      <= '0;
         code_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         good_ff      <= good_in;
         esc_ff       <= esc_in;
         cnt_ff       <= cnt_in;
         ctrl_ff      <= ctrl_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire && emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_idx_ff  <= emit_idx;
         rsp_val_ff  <= emit_val;
         rsp_ctrl_ff <= emit_ctrl;
         rsp_code_ff <= emit_code;
         rsp_len_ff  <= emit_len;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = RSP_W'({rsp_len_ff, rsp_code_ff, rsp_ctrl_ff, rsp_val_ff, rsp_idx_ff});

   `include "dle_stuffed_frame_receiver_assert.svh"

   `DLE_ASSERT_ALWAYS(a_good_within_open, clock, reset, !good_ff || open_ff, "good frame state outside an open frame")
   `DLE_ASSERT_ALWAYS(a_escape_in_good, clock, reset, !esc_ff || good_ff, "escape pending outside a good frame")
   `DLE_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= CNT_W'(DATA_BUFFER_SIZE + 2), "byte count ran past the overflow point")

endmodule
